// ===== src/thvn_pkg.sv =====
// Shared types, fixed-point constants and pipeline latencies for the terrain height
// value-noise pipeline. No dependencies.
package thvn_pkg;

    // Q24 signed 48-bit working format
    typedef logic signed [47:0] q_t;
    typedef logic [23:0]        frac_t;
    typedef logic signed [24:0] corner_t;

    localparam int COORD_BITS = 16;
    localparam int OCTAVES    = 5;
    localparam int FIELD_W    = 16;
    localparam int HEIGHT_W   = 23;
    localparam int CQ_W       = COORD_BITS - 2;

    // coordinate * 0.025: quotient by 5 through a reciprocal, remainder by table
    localparam logic [15:0] DIV5_MAGIC = 16'd52429;
    localparam int          DIV5_SHIFT = 18;
    localparam logic [20:0] SCALE_REM0 = 21'((64'd0 * 64'd2097152 + 64'd2) / 64'd5);
    localparam logic [20:0] SCALE_REM1 = 21'((64'd1 * 64'd2097152 + 64'd2) / 64'd5);
    localparam logic [20:0] SCALE_REM2 = 21'((64'd2 * 64'd2097152 + 64'd2) / 64'd5);
    localparam logic [20:0] SCALE_REM3 = 21'((64'd3 * 64'd2097152 + 64'd2) / 64'd5);
    localparam logic [20:0] SCALE_REM4 = 21'((64'd4 * 64'd2097152 + 64'd2) / 64'd5);

    localparam q_t Q_ONE   = 48'sd16777216;
    localparam q_t Q_THREE = 48'sd50331648;
    localparam q_t Q_075   = q_t'((64'd75 * 64'd16777216 + 64'd50) / 64'd100);
    localparam q_t Q_015   = q_t'((64'd15 * 64'd16777216 + 64'd50) / 64'd100);
    localparam q_t Q_04    = q_t'((64'd4 * 64'd16777216 + 64'd5) / 64'd10);
    localparam q_t Q_0002  = q_t'((64'd2 * 64'd16777216 + 64'd500) / 64'd1000);
    localparam q_t Q_66    = q_t'(64'd66 * 64'd16777216);
    localparam q_t Q_275   = q_t'(64'd275 * 64'd16777216);
    localparam q_t Q_12    = q_t'(64'd12 * 64'd16777216);
    localparam q_t HASH_OFF = q_t'((64'd1919 * 64'd16777216 + 64'd50) / 64'd100);

    localparam q_t ROT_XX = q_t'((64'd13623 * 64'd16777216 + 64'd5000) / 64'd10000);
    localparam q_t ROT_ZX = q_t'((64'd17531 * 64'd16777216 + 64'd5000) / 64'd10000);
    localparam q_t ROT_XZ = -q_t'((64'd17131 * 64'd16777216 + 64'd5000) / 64'd10000);
    localparam q_t ROT_ZZ = q_t'((64'd14623 * 64'd16777216 + 64'd5000) / 64'd10000);

    // reciprocals of the hash periods, 40 fraction bits
    localparam logic [39:0] RECIP_A =
        40'(((64'd1 << 40) * 64'd100000 + 64'd153982) / 64'd307965);
    localparam logic [39:0] RECIP_B =
        40'(((64'd1 << 40) * 64'd10000 + 64'd35617) / 64'd71235);

    localparam logic signed [36:0] H_MAX = 37'sd4194303;
    localparam logic signed [36:0] H_MIN = -37'sd4194304;

    // latencies in cycles
    localparam int L_MUL   = 4;
    localparam int L_FRAC  = 4;
    localparam int L_HASH  = L_FRAC + 3 + 2 * L_MUL;
    localparam int L_BLEND = L_MUL + 2;
    localparam int L_NOISE = 1 + L_HASH + 2 * L_BLEND;
    localparam int L_OCT   = L_NOISE + L_MUL + 1;
    localparam int L_SCALE = 3;
    localparam int L_WARP  = L_NOISE + 3 * L_MUL + 1;
    localparam int L_FIN   = 6 * L_MUL + L_NOISE + 1;
    localparam int L_TOTAL = L_SCALE + L_WARP + OCTAVES * L_OCT + L_FIN + 2;

    function automatic logic [20:0] scale_rem(input logic [2:0] r);
        logic [20:0] v;
        case (r)
            3'd0:    v = SCALE_REM0;
            3'd1:    v = SCALE_REM1;
            3'd2:    v = SCALE_REM2;
            3'd3:    v = SCALE_REM3;
            3'd4:    v = SCALE_REM4;
            default: v = SCALE_REM0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/terrain_height_value_noise.sv =====
// Terrain height from a grid point: coordinate scaling, domain warp weight,
// octave chain and ridge term.
// Throughput one point per cycle; the whole pipeline holds while an output waits.
// Reset (aresetn low at a clock edge) clears the valid bits only; s_tready is low
// while aresetn is low.
// Uses thvn_pkg, thvn_mulq, thvn_noise and thvn_octave.
module terrain_height_value_noise (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] x_coord, [31:16] z_coord
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [22:0] height, [23] zero
);
    import thvn_pkg::*;

    logic ce;
    logic [L_TOTAL-1:0] v_reg;

    assign ce       = !v_reg[L_TOTAL-1] || m_tready;
    assign s_tready = ce && aresetn;
    assign m_tvalid = v_reg[L_TOTAL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[L_TOTAL-2:0], s_tvalid};
        end
    end

    // coordinate * 0.025, rounded: floor((c*2^21 + 2)/5)
    q_t xz0 [2];

    for (genvar g = 0; g < 2; g++) begin : g_scale
        logic [COORD_BITS-1:0]    c_in, c_reg;
        logic [COORD_BITS+15:0]   pr;
        logic [CQ_W-1:0]          est_reg, cq_reg;
        logic [COORD_BITS:0]      p5;
        logic [2:0]               cr_reg;
        q_t                       q_reg;

        assign c_in = s_tdata[g*FIELD_W +: COORD_BITS];
        assign pr   = c_in * DIV5_MAGIC;
        assign p5   = est_reg * 3'd5;

        always_ff @(posedge aclk) begin
            if (ce) begin
                c_reg   <= c_in;
                est_reg <= pr[DIV5_SHIFT+CQ_W-1:DIV5_SHIFT];
                // estimate is exact or one too high
                if ({1'b0, c_reg} < p5) begin
                    cq_reg <= est_reg - 1'b1;
                    cr_reg <= 3'(({1'b0, c_reg} + 5) - p5);
                end else begin
                    cq_reg <= est_reg;
                    cr_reg <= 3'({1'b0, c_reg} - p5);
                end
                q_reg <= q_t'({cq_reg, 21'd0}) + q_t'(scale_rem(cr_reg));
            end
        end

        assign xz0[g] = q_reg;
    end

    // warp weight w = 66*(0.75*N(x/4, z/4) + 0.15)^2
    q_t nw, t1, t_reg, tt, w0;
    q_t x0d_reg [L_WARP];
    q_t z0d_reg [L_WARP];

    thvn_noise u_warp (.aclk(aclk), .ce(ce), .x(xz0[0] >>> 2), .y(xz0[1] >>> 2), .n(nw));
    thvn_mulq  u_t1   (.aclk(aclk), .ce(ce), .a(nw),    .b(Q_075), .p(t1));
    thvn_mulq  u_tt   (.aclk(aclk), .ce(ce), .a(t_reg), .b(t_reg), .p(tt));
    thvn_mulq  u_w0   (.aclk(aclk), .ce(ce), .a(Q_66),  .b(tt),    .p(w0));

    always_ff @(posedge aclk) begin
        if (ce) begin
            t_reg <= t1 + Q_015;
            x0d_reg[0] <= xz0[0];
            z0d_reg[0] <= xz0[1];
            for (int k = 1; k < L_WARP; k++) begin
                x0d_reg[k] <= x0d_reg[k-1];
                z0d_reg[k] <= z0d_reg[k-1];
            end
        end
    end

    // octave chain
    q_t ox [OCTAVES+1];
    q_t oz [OCTAVES+1];
    q_t ow [OCTAVES+1];
    q_t of [OCTAVES+1];

    assign ox[0] = x0d_reg[L_WARP-1];
    assign oz[0] = z0d_reg[L_WARP-1];
    assign ow[0] = w0;
    assign of[0] = '0;

    for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
        thvn_octave u_oct (
            .aclk(aclk), .ce(ce),
            .x_in(ox[k]), .z_in(oz[k]), .w_in(ow[k]), .f_in(of[k]),
            .x_out(ox[k+1]), .z_out(oz[k+1]), .w_out(ow[k+1]), .f_out(of[k+1])
        );
    end

    // ridge term 275*|N(0.002x, 0.002z)|^5
    q_t xs, zs, na, a_reg, a2, a3, a4, a5, p275, fsum_reg;
    q_t ad_reg [3*L_MUL];
    q_t fd_reg [L_FIN];

    thvn_mulq  u_xs (.aclk(aclk), .ce(ce), .a(ox[OCTAVES]), .b(Q_0002), .p(xs));
    thvn_mulq  u_zs (.aclk(aclk), .ce(ce), .a(oz[OCTAVES]), .b(Q_0002), .p(zs));
    thvn_noise u_rn (.aclk(aclk), .ce(ce), .x(xs), .y(zs), .n(na));
    thvn_mulq  u_a2 (.aclk(aclk), .ce(ce), .a(a_reg), .b(a_reg), .p(a2));
    thvn_mulq  u_a3 (.aclk(aclk), .ce(ce), .a(a2), .b(ad_reg[L_MUL-1]),   .p(a3));
    thvn_mulq  u_a4 (.aclk(aclk), .ce(ce), .a(a3), .b(ad_reg[2*L_MUL-1]), .p(a4));
    thvn_mulq  u_a5 (.aclk(aclk), .ce(ce), .a(a4), .b(ad_reg[3*L_MUL-1]), .p(a5));
    thvn_mulq  u_pr (.aclk(aclk), .ce(ce), .a(a5), .b(Q_275), .p(p275));

    logic signed [48:0] fr;
    logic signed [36:0] hs;
    logic [HEIGHT_W-1:0] height_reg;

    assign fr = {fsum_reg[47], fsum_reg} + 49'sd2048;
    assign hs = fr[48:12];

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_reg <= na[47] ? -na : na;
            ad_reg[0] <= a_reg;
            for (int k = 1; k < 3 * L_MUL; k++) ad_reg[k] <= ad_reg[k-1];
            fd_reg[0] <= of[OCTAVES];
            for (int k = 1; k < L_FIN; k++) fd_reg[k] <= fd_reg[k-1];
            fsum_reg <= fd_reg[L_FIN-1] + p275 + Q_12;
            if (hs > H_MAX) begin
                height_reg <= H_MAX[HEIGHT_W-1:0];
            end else if (hs < H_MIN) begin
                height_reg <= H_MIN[HEIGHT_W-1:0];
            end else begin
                height_reg <= hs[HEIGHT_W-1:0];
            end
        end
    end

    assign m_tdata = {1'b0, height_reg};

endmodule

// ===== src/thvn_mulq.sv =====
// Pipelined Q24 multiplier: sign-magnitude product from 24x24 partial products,
// magnitude truncated, wrapped to 48 bits. Uses thvn_pkg.
module thvn_mulq (
    input  logic          aclk,
    input  logic          ce,
    input  thvn_pkg::q_t  a,
    input  thvn_pkg::q_t  b,
    output thvn_pkg::q_t  p
);
    import thvn_pkg::*;

    logic [2:0]  neg_reg;
    logic [47:0] ma_reg, mb_reg;
    logic [23:0] hh_reg, ll_reg;
    logic [47:0] hl_reg, lh_reg;
    logic [47:0] sum_reg;
    q_t          p_reg;
    logic [47:0] hh, hl, lh, ll;

    assign hh = ma_reg[47:24] * mb_reg[47:24];
    assign hl = ma_reg[47:24] * mb_reg[23:0];
    assign lh = ma_reg[23:0]  * mb_reg[47:24];
    assign ll = ma_reg[23:0]  * mb_reg[23:0];

    always_ff @(posedge aclk) begin
        if (ce) begin
            neg_reg <= {neg_reg[1:0], a[47] ^ b[47]};
            ma_reg  <= a[47] ? (48'd0 - 48'(a)) : 48'(a);
            mb_reg  <= b[47] ? (48'd0 - 48'(b)) : 48'(b);
            hh_reg  <= hh[23:0];
            hl_reg  <= hl;
            lh_reg  <= lh;
            ll_reg  <= ll[47:24];
            sum_reg <= {hh_reg, 24'd0} + hl_reg + lh_reg + {24'd0, ll_reg};
            p_reg   <= neg_reg[2] ? q_t'(48'd0 - sum_reg) : q_t'(sum_reg);
        end
    end

    assign p = p_reg;

endmodule

// ===== src/thvn_hash.sv =====
// Lattice corner hash: floor fractions by reciprocal multiply, then the mixing
// products. Uses thvn_pkg and thvn_mulq.
module thvn_hash (
    input  logic              aclk,
    input  logic              ce,
    input  thvn_pkg::corner_t i,
    input  thvn_pkg::corner_t j,
    output thvn_pkg::frac_t   h
);
    import thvn_pkg::*;

    frac_t fr [2];

    for (genvar g = 0; g < 2; g++) begin : g_frac
        corner_t     v;
        logic [39:0] recip;
        logic        neg0_reg, neg1_reg, neg2_reg;
        logic [23:0] m_reg;
        logic [39:0] plo_reg, f_reg, refl;
        logic [15:0] phi_reg;
        frac_t       fr_reg;
        logic [47:0] plo;
        logic [39:0] phi;

        assign v     = (g == 0) ? i : j;
        assign recip = (g == 0) ? RECIP_A : RECIP_B;
        assign plo   = m_reg * recip[23:0];
        assign phi   = m_reg * recip[39:24];
        // negative corners reflect the fraction
        assign refl  = (neg2_reg && f_reg != 40'd0) ? (40'd0 - f_reg) : f_reg;

        always_ff @(posedge aclk) begin
            if (ce) begin
                neg0_reg <= v[24];
                m_reg    <= v[24] ? 24'(-v) : 24'(v);
                neg1_reg <= neg0_reg;
                plo_reg  <= plo[39:0];
                phi_reg  <= phi[15:0];
                neg2_reg <= neg1_reg;
                f_reg    <= plo_reg + {phi_reg, 24'd0};
                fr_reg   <= refl[39:16];
            end
        end

        assign fr[g] = fr_reg;
    end

    q_t a_reg, b_reg, ab_reg, ba_reg;
    q_t r1, r2, r_reg, u_reg, w_reg, prod;
    q_t ad_reg [L_MUL+1];
    q_t bd_reg [L_MUL+1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_reg  <= q_t'({24'd0, fr[0]});
            b_reg  <= q_t'({24'd0, fr[1]});
            ab_reg <= q_t'({24'd0, fr[0]}) + HASH_OFF;
            ba_reg <= q_t'({24'd0, fr[1]}) + HASH_OFF;
            ad_reg[0] <= a_reg;
            bd_reg[0] <= b_reg;
            for (int k = 1; k <= L_MUL; k++) begin
                ad_reg[k] <= ad_reg[k-1];
                bd_reg[k] <= bd_reg[k-1];
            end
            r_reg <= r1 + r2;
            u_reg <= ad_reg[L_MUL] + r_reg;
            w_reg <= bd_reg[L_MUL] + r_reg;
        end
    end

    thvn_mulq u_mul_r1 (.aclk(aclk), .ce(ce), .a(a_reg), .b(ba_reg), .p(r1));
    thvn_mulq u_mul_r2 (.aclk(aclk), .ce(ce), .a(b_reg), .b(ab_reg), .p(r2));
    thvn_mulq u_mul_p  (.aclk(aclk), .ce(ce), .a(u_reg), .b(w_reg),  .p(prod));

    assign h = prod[23:0];

endmodule

// ===== src/thvn_noise.sv =====
// Smoothstep value noise: four corner hashes, blend weights, two blend levels.
// Uses thvn_pkg, thvn_hash and thvn_mulq.
module thvn_noise (
    input  logic         aclk,
    input  logic         ce,
    input  thvn_pkg::q_t x,
    input  thvn_pkg::q_t y,
    output thvn_pkg::q_t n
);
    import thvn_pkg::*;

    localparam int SX_D = L_HASH - 2 * L_MUL + 1;
    localparam int SY_D = SX_D + L_BLEND;

    frac_t   fx_reg, fy_reg;
    corner_t ix_reg, ix1_reg, iy_reg, iy1_reg;
    q_t      tx_reg, ty_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            fx_reg  <= x[23:0];
            fy_reg  <= y[23:0];
            ix_reg  <= {x[47], x[47:24]};
            ix1_reg <= {x[47], x[47:24]} + 25'sd1;
            iy_reg  <= {y[47], y[47:24]};
            iy1_reg <= {y[47], y[47:24]} + 25'sd1;
            tx_reg  <= Q_THREE - q_t'({23'd0, x[23:0], 1'b0});
            ty_reg  <= Q_THREE - q_t'({23'd0, y[23:0], 1'b0});
        end
    end

    frac_t h00, h10, h01, h11;

    thvn_hash u_h00 (.aclk(aclk), .ce(ce), .i(ix_reg),  .j(iy_reg),  .h(h00));
    thvn_hash u_h10 (.aclk(aclk), .ce(ce), .i(ix1_reg), .j(iy_reg),  .h(h10));
    thvn_hash u_h01 (.aclk(aclk), .ce(ce), .i(ix_reg),  .j(iy1_reg), .h(h01));
    thvn_hash u_h11 (.aclk(aclk), .ce(ce), .i(ix1_reg), .j(iy1_reg), .h(h11));

    // blend weights s = f*f*(3 - 2f)
    q_t fxx, fyy, sx, sy;
    q_t txd_reg [L_MUL];
    q_t tyd_reg [L_MUL];
    q_t sxd_reg [SX_D];
    q_t syd_reg [SY_D];

    thvn_mulq u_fxx (.aclk(aclk), .ce(ce), .a(q_t'({24'd0, fx_reg})),
                     .b(q_t'({24'd0, fx_reg})), .p(fxx));
    thvn_mulq u_fyy (.aclk(aclk), .ce(ce), .a(q_t'({24'd0, fy_reg})),
                     .b(q_t'({24'd0, fy_reg})), .p(fyy));
    thvn_mulq u_sx  (.aclk(aclk), .ce(ce), .a(fxx), .b(txd_reg[L_MUL-1]), .p(sx));
    thvn_mulq u_sy  (.aclk(aclk), .ce(ce), .a(fyy), .b(tyd_reg[L_MUL-1]), .p(sy));

    always_ff @(posedge aclk) begin
        if (ce) begin
            txd_reg[0] <= tx_reg;
            tyd_reg[0] <= ty_reg;
            for (int k = 1; k < L_MUL; k++) begin
                txd_reg[k] <= txd_reg[k-1];
                tyd_reg[k] <= tyd_reg[k-1];
            end
            sxd_reg[0] <= sx;
            for (int k = 1; k < SX_D; k++) sxd_reg[k] <= sxd_reg[k-1];
            syd_reg[0] <= sy;
            for (int k = 1; k < SY_D; k++) syd_reg[k] <= syd_reg[k-1];
        end
    end

    // first level: rows along x
    q_t d_lo_reg, d_hi_reg, p_lo, p_hi, lo_reg, hi_reg;
    q_t alo_reg [L_MUL+1];
    q_t ahi_reg [L_MUL+1];

    thvn_mulq u_blo (.aclk(aclk), .ce(ce), .a(d_lo_reg), .b(sxd_reg[SX_D-1]), .p(p_lo));
    thvn_mulq u_bhi (.aclk(aclk), .ce(ce), .a(d_hi_reg), .b(sxd_reg[SX_D-1]), .p(p_hi));

    // second level: along y
    q_t d_y_reg, p_y, n_reg;
    q_t ld_reg [L_MUL+1];

    thvn_mulq u_by (.aclk(aclk), .ce(ce), .a(d_y_reg), .b(syd_reg[SY_D-1]), .p(p_y));

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_lo_reg   <= q_t'({24'd0, h10}) - q_t'({24'd0, h00});
            d_hi_reg   <= q_t'({24'd0, h11}) - q_t'({24'd0, h01});
            alo_reg[0] <= q_t'({24'd0, h00});
            ahi_reg[0] <= q_t'({24'd0, h01});
            for (int k = 1; k <= L_MUL; k++) begin
                alo_reg[k] <= alo_reg[k-1];
                ahi_reg[k] <= ahi_reg[k-1];
            end
            lo_reg    <= alo_reg[L_MUL] + p_lo;
            hi_reg    <= ahi_reg[L_MUL] + p_hi;
            d_y_reg   <= hi_reg - lo_reg;
            ld_reg[0] <= lo_reg;
            for (int k = 1; k <= L_MUL; k++) ld_reg[k] <= ld_reg[k-1];
            n_reg     <= ld_reg[L_MUL] + p_y;
        end
    end

    assign n = n_reg;

endmodule

// ===== src/thvn_octave.sv =====
// One fractal octave: f += w*N(x, z), w -> -0.4w, (x, z) rotated.
// Uses thvn_pkg, thvn_noise and thvn_mulq.
module thvn_octave (
    input  logic         aclk,
    input  logic         ce,
    input  thvn_pkg::q_t x_in,
    input  thvn_pkg::q_t z_in,
    input  thvn_pkg::q_t w_in,
    input  thvn_pkg::q_t f_in,
    output thvn_pkg::q_t x_out,
    output thvn_pkg::q_t z_out,
    output thvn_pkg::q_t w_out,
    output thvn_pkg::q_t f_out
);
    import thvn_pkg::*;

    localparam int ROT_D = L_OCT - L_MUL - 1;
    localparam int F_D   = L_NOISE + L_MUL;

    q_t nz, wn, mxx, mxz, mzx, mzz, wq;
    q_t nx_reg, nzr_reg, wneg_reg, f_reg;
    q_t wd_reg [L_NOISE];
    q_t fd_reg [F_D];
    q_t xd_reg [ROT_D];
    q_t zd_reg [ROT_D];
    q_t wod_reg [ROT_D];

    thvn_noise u_noise (.aclk(aclk), .ce(ce), .x(x_in), .y(z_in), .n(nz));
    thvn_mulq  u_wn    (.aclk(aclk), .ce(ce), .a(wd_reg[L_NOISE-1]), .b(nz), .p(wn));

    thvn_mulq u_xx (.aclk(aclk), .ce(ce), .a(ROT_XX), .b(x_in), .p(mxx));
    thvn_mulq u_xz (.aclk(aclk), .ce(ce), .a(ROT_XZ), .b(z_in), .p(mxz));
    thvn_mulq u_zx (.aclk(aclk), .ce(ce), .a(ROT_ZX), .b(x_in), .p(mzx));
    thvn_mulq u_zz (.aclk(aclk), .ce(ce), .a(ROT_ZZ), .b(z_in), .p(mzz));
    thvn_mulq u_w4 (.aclk(aclk), .ce(ce), .a(w_in),   .b(Q_04), .p(wq));

    always_ff @(posedge aclk) begin
        if (ce) begin
            wd_reg[0] <= w_in;
            for (int k = 1; k < L_NOISE; k++) wd_reg[k] <= wd_reg[k-1];
            fd_reg[0] <= f_in;
            for (int k = 1; k < F_D; k++) fd_reg[k] <= fd_reg[k-1];
            f_reg <= fd_reg[F_D-1] + wn;

            nx_reg   <= mxx + mxz;
            nzr_reg  <= mzx + mzz;
            wneg_reg <= -wq;
            xd_reg[0]  <= nx_reg;
            zd_reg[0]  <= nzr_reg;
            wod_reg[0] <= wneg_reg;
            for (int k = 1; k < ROT_D; k++) begin
                xd_reg[k]  <= xd_reg[k-1];
                zd_reg[k]  <= zd_reg[k-1];
                wod_reg[k] <= wod_reg[k-1];
            end
        end
    end

    assign x_out = xd_reg[ROT_D-1];
    assign z_out = zd_reg[ROT_D-1];
    assign w_out = wod_reg[ROT_D-1];
    assign f_out = f_reg;

endmodule
